### design/gsp_pkg.sv
`timescale 1ns / 1ps

package gsp_pkg;

   // Store geometry: a cell address is {row, column}.
   localparam int MAX_WIDTH  = 32;
   localparam int MAX_HEIGHT = 32;
   localparam int XW         = 5;
   localparam int YW         = 5;
   localparam int AW         = XW + YW;
   localparam int CELLS      = MAX_WIDTH * MAX_HEIGHT;
   localparam int DW         = 11;
   localparam int LW         = 10;
   localparam int CW         = 6;

   localparam logic [DW-1:0] DIST_INF = '1;

   // Request modes.
   localparam logic [1:0] MODE_LOAD  = 2'd0;
   localparam logic [1:0] MODE_SOLVE = 2'd1;
   localparam logic [1:0] MODE_STEP  = 2'd2;

   // Result kinds.
   localparam logic KIND_SOLVE = 1'b0;
   localparam logic KIND_STEP  = 1'b1;

   // Status codes.
   localparam logic [1:0] ST_OK          = 2'd0;
   localparam logic [1:0] ST_UNREACHABLE = 2'd1;
   localparam logic [1:0] ST_BAD_END     = 2'd2;
   localparam logic [1:0] ST_BAD_STEP    = 2'd3;

   // Neighbor order during relaxation.
   localparam logic [1:0] DIR_UP    = 2'd0;
   localparam logic [1:0] DIR_DOWN  = 2'd1;
   localparam logic [1:0] DIR_LEFT  = 2'd2;
   localparam logic [1:0] DIR_RIGHT = 2'd3;

   // Register indexes.
   localparam logic REG_WIDTH  = 1'b0;
   localparam logic REG_HEIGHT = 1'b1;

   typedef struct packed {
      logic [CW-1:0] width;
      logic [CW-1:0] height;
   } cfg_type;

   typedef struct packed {
      logic [1:0]    mode;
      logic [XW-1:0] cell_x;
      logic [YW-1:0] cell_y;
      logic          cell_blocked;
      logic [XW-1:0] start_x;
      logic [YW-1:0] start_y;
      logic [XW-1:0] end_x;
      logic [YW-1:0] end_y;
      logic [LW-1:0] step_index;
   } req_item_type;

   typedef struct packed {
      logic          result_kind;
      logic [1:0]    status;
      logic [LW-1:0] path_length;
      logic [XW-1:0] step_x;
      logic [YW-1:0] step_y;
   } result_type;

   typedef struct packed {
      logic          blocked;
      logic [DW-1:0] distance;
      logic [AW-1:0] pred;
   } cell_word_type;

endpackage

### design/gsp_csr.sv
`timescale 1ns / 1ps

module gsp_csr import gsp_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          csr_psel,
   input  logic          csr_penable,
   input  logic          csr_pwrite,
   input  logic [2:0]    csr_paddr,
   input  logic [31:0]   csr_pwdata,
   output logic [31:0]   csr_prdata,
   output logic          csr_pready,
   output cfg_type       cfg
);

   logic [CW-1:0] width_ff;
   logic [CW-1:0] height_ff;
   logic          wr_en;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;

   // Register writes complete in the access phase.
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= CW'(32);
         height_ff <= CW'(32);
      end else if (wr_en) begin
         unique case (csr_paddr[2])
            REG_WIDTH:  width_ff  <= csr_pwdata[CW-1:0];
            REG_HEIGHT: height_ff <= csr_pwdata[CW-1:0];
            default: ;
         endcase
      end
   end

   // Read data is returned combinationally.
   always_comb begin
      unique case (csr_paddr[2])
         REG_WIDTH:  csr_prdata = {{(32-CW){1'b0}}, width_ff};
         REG_HEIGHT: csr_prdata = {{(32-CW){1'b0}}, height_ff};
         default:    csr_prdata = '0;
      endcase
   end

   assign cfg.width  = width_ff;
   assign cfg.height = height_ff;

endmodule

### design/gsp_out_stage.sv
`timescale 1ns / 1ps

module gsp_out_stage import gsp_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   input  result_type push_item,
   output logic       push_ready,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output result_type rsp_item
);

   logic       valid_ff;
   result_type item_ff;

   assign push_ready = !valid_ff || rsp_ready;
   assign rsp_valid  = valid_ff;
   assign rsp_item   = item_ff;

   // Output register: holds one result item until the sink takes it.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (push_ready) begin
         valid_ff <= push;
      end
   end

   always_ff @(posedge clock) begin
      if (push && push_ready) begin
         item_ff <= push_item;
      end
   end

endmodule

### design/gsp_engine.sv
`timescale 1ns / 1ps

module gsp_engine import gsp_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  cfg_type      cfg,
   input  logic         req_valid,
   input  req_item_type req_item,
   output logic         req_ready,
   output logic         res_push,
   output result_type   res_item,
   input  logic         res_ready
);

   localparam logic [3:0] S_IDLE    = 4'd0;
   localparam logic [3:0] S_STEP    = 4'd1;
   localparam logic [3:0] S_CHK_S   = 4'd2;
   localparam logic [3:0] S_CHK_E   = 4'd3;
   localparam logic [3:0] S_INIT    = 4'd4;
   localparam logic [3:0] S_ZERO    = 4'd5;
   localparam logic [3:0] S_LVL     = 4'd6;
   localparam logic [3:0] S_LVL_CHK = 4'd7;
   localparam logic [3:0] S_SC_RD   = 4'd8;
   localparam logic [3:0] S_SC_CHK  = 4'd9;
   localparam logic [3:0] S_NB_SEL  = 4'd10;
   localparam logic [3:0] S_NB_CHK  = 4'd11;
   localparam logic [3:0] S_ADV     = 4'd12;
   localparam logic [3:0] S_TR_RD   = 4'd13;
   localparam logic [3:0] S_TR_CHK  = 4'd14;
   localparam logic [3:0] S_DONE    = 4'd15;

   // Memories.
   cell_word_type cell_mem [CELLS];
   logic [AW-1:0] path_mem [CELLS];
   cell_word_type cell_rd_ff;
   logic [AW-1:0] path_rd_ff;

   logic          cell_re;
   logic [AW-1:0] cell_raddr;
   logic          we_blk, we_dist, we_pred;
   logic [AW-1:0] cell_waddr;
   logic          wd_blk;
   logic [DW-1:0] wd_dist;
   logic          path_re, path_we;

   // Control state.
   logic [3:0]    state_ff, state_in;
   logic [AW-1:0] start_ff, start_in;
   logic [AW-1:0] fin_ff, fin_in;
   logic [XW-1:0] x_ff, x_in;
   logic [YW-1:0] y_ff, y_in;
   logic [DW-1:0] d_ff, d_in;
   logic          found_ff, found_in;
   logic [AW-1:0] cur_ff, cur_in;
   logic [1:0]    k_ff, k_in;
   logic [AW-1:0] nb_ff, nb_in;
   logic [LW-1:0] len_ff, len_in;
   logic [1:0]    status_ff, status_in;
   logic          idx_ok_ff, idx_ok_in;

   logic [CW-1:0] w_eff, h_eff, w_m1, h_m1;
   logic          accept, bad_bounds, scan_last;
   logic [XW-1:0] cx;
   logic [YW-1:0] cy;
   logic          nb_exists;
   logic [AW-1:0] nb_addr;
   logic [AW-1:0] req_start, req_fin;

   // Grid size in use, clipped to the store.
   assign w_eff = (cfg.width > CW'(MAX_WIDTH)) ? CW'(MAX_WIDTH) : cfg.width;
   assign h_eff = (cfg.height > CW'(MAX_HEIGHT)) ? CW'(MAX_HEIGHT) : cfg.height;
   assign w_m1  = w_eff - CW'(1);
   assign h_m1  = h_eff - CW'(1);

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;
   assign req_start = {req_item.start_y, req_item.start_x};
   assign req_fin   = {req_item.end_y, req_item.end_x};

   assign bad_bounds = ({1'b0, req_item.start_x} >= w_eff) ||
                       ({1'b0, req_item.start_y} >= h_eff) ||
                       ({1'b0, req_item.end_x} >= w_eff) ||
                       ({1'b0, req_item.end_y} >= h_eff);

   assign scan_last = (x_ff == w_m1[XW-1:0]) && (y_ff == h_m1[YW-1:0]);

   // Neighbor of the cell being settled, in the order up, down, left, right.
   assign cx = cur_ff[XW-1:0];
   assign cy = cur_ff[AW-1:XW];

   always_comb begin
      unique case (k_ff)
         DIR_UP: begin
            nb_exists = (cy != '0);
            nb_addr   = {cy - YW'(1), cx};
         end
         DIR_DOWN: begin
            nb_exists = (({1'b0, cy} + CW'(1)) < h_eff);
            nb_addr   = {cy + YW'(1), cx};
         end
         DIR_LEFT: begin
            nb_exists = (cx != '0);
            nb_addr   = {cy, cx - XW'(1)};
         end
         DIR_RIGHT: begin
            nb_exists = (({1'b0, cx} + CW'(1)) < w_eff);
            nb_addr   = {cy, cx + XW'(1)};
         end
         default: begin
            nb_exists = 1'b0;
            nb_addr   = cur_ff;
         end
      endcase
   end

   // Sequencer.
   always_comb begin
      state_in  = state_ff;
      start_in  = start_ff;
      fin_in    = fin_ff;
      x_in      = x_ff;
      y_in      = y_ff;
      d_in      = d_ff;
      found_in  = found_ff;
      cur_in    = cur_ff;
      k_in      = k_ff;
      nb_in     = nb_ff;
      len_in    = len_ff;
      status_in = status_ff;
      idx_ok_in = idx_ok_ff;

      cell_re    = 1'b0;
      cell_raddr = cur_ff;
      we_blk     = 1'b0;
      we_dist    = 1'b0;
      we_pred    = 1'b0;
      cell_waddr = nb_ff;
      wd_blk     = req_item.cell_blocked;
      wd_dist    = d_ff + DW'(1);
      path_re    = 1'b0;
      path_we    = 1'b0;

      res_push = 1'b0;
      res_item = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               case (req_item.mode)
                  MODE_LOAD: begin
                     we_blk     = 1'b1;
                     cell_waddr = {req_item.cell_y, req_item.cell_x};
                  end
                  MODE_SOLVE: begin
                     len_in   = '0;
                     start_in = req_start;
                     fin_in   = req_fin;
                     if (bad_bounds) begin
                        status_in = ST_BAD_END;
                        state_in  = S_DONE;
                     end else begin
                        cell_re    = 1'b1;
                        cell_raddr = req_start;
                        state_in   = S_CHK_S;
                     end
                  end
                  MODE_STEP: begin
                     path_re   = 1'b1;
                     idx_ok_in = (req_item.step_index < len_ff);
                     state_in  = S_STEP;
                  end
                  default: ;
               endcase
            end
         end

         S_STEP: begin
            res_push             = 1'b1;
            res_item.result_kind = KIND_STEP;
            res_item.path_length = len_ff;
            if (idx_ok_ff) begin
               res_item.status = ST_OK;
               res_item.step_x = path_rd_ff[XW-1:0];
               res_item.step_y = path_rd_ff[AW-1:XW];
            end else begin
               res_item.status = ST_BAD_STEP;
            end
            if (res_ready) begin
               state_in = S_IDLE;
            end
         end

         S_CHK_S: begin
            if (cell_rd_ff.blocked) begin
               status_in = ST_BAD_END;
               state_in  = S_DONE;
            end else begin
               cell_re    = 1'b1;
               cell_raddr = fin_ff;
               state_in   = S_CHK_E;
            end
         end

         S_CHK_E: begin
            if (cell_rd_ff.blocked) begin
               status_in = ST_BAD_END;
               state_in  = S_DONE;
            end else if (start_ff == fin_ff) begin
               status_in = ST_OK;
               state_in  = S_DONE;
            end else begin
               x_in     = '0;
               y_in     = '0;
               state_in = S_INIT;
            end
         end

         // Every cell in use starts at infinite distance.
         S_INIT: begin
            we_dist    = 1'b1;
            cell_waddr = {y_ff, x_ff};
            wd_dist    = DIST_INF;
            if (scan_last) begin
               state_in = S_ZERO;
            end else if (x_ff == w_m1[XW-1:0]) begin
               x_in = '0;
               y_in = y_ff + YW'(1);
            end else begin
               x_in = x_ff + XW'(1);
            end
         end

         S_ZERO: begin
            we_dist    = 1'b1;
            cell_waddr = start_ff;
            wd_dist    = '0;
            d_in       = '0;
            state_in   = S_LVL;
         end

         // A level starts by checking whether the end cell has been reached.
         S_LVL: begin
            cell_re    = 1'b1;
            cell_raddr = fin_ff;
            state_in   = S_LVL_CHK;
         end

         S_LVL_CHK: begin
            if (cell_rd_ff.distance == d_ff) begin
               cur_in   = fin_ff;
               state_in = S_TR_RD;
            end else begin
               found_in = 1'b0;
               x_in     = '0;
               y_in     = '0;
               state_in = S_SC_RD;
            end
         end

         // Raster sweep that settles the cells of the current level.
         S_SC_RD: begin
            cell_re    = 1'b1;
            cell_raddr = {y_ff, x_ff};
            state_in   = S_SC_CHK;
         end

         S_SC_CHK: begin
            if (cell_rd_ff.distance == d_ff) begin
               found_in = 1'b1;
               cur_in   = {y_ff, x_ff};
               k_in     = DIR_UP;
               state_in = S_NB_SEL;
            end else begin
               state_in = S_ADV;
            end
         end

         S_NB_SEL: begin
            if (nb_exists) begin
               cell_re    = 1'b1;
               cell_raddr = nb_addr;
               nb_in      = nb_addr;
               state_in   = S_NB_CHK;
            end else if (k_ff == DIR_RIGHT) begin
               state_in = S_ADV;
            end else begin
               k_in = k_ff + 2'd1;
            end
         end

         // Relax: a free neighbor farther than this level takes level plus one.
         S_NB_CHK: begin
            if (!cell_rd_ff.blocked && (cell_rd_ff.distance > d_ff)) begin
               we_dist    = 1'b1;
               we_pred    = 1'b1;
               cell_waddr = nb_ff;
               wd_dist    = d_ff + DW'(1);
            end
            if (k_ff == DIR_RIGHT) begin
               state_in = S_ADV;
            end else begin
               k_in     = k_ff + 2'd1;
               state_in = S_NB_SEL;
            end
         end

         S_ADV: begin
            if (scan_last) begin
               if (found_ff) begin
                  d_in     = d_ff + DW'(1);
                  state_in = S_LVL;
               end else begin
                  status_in = ST_UNREACHABLE;
                  state_in  = S_DONE;
               end
            end else if (x_ff == w_m1[XW-1:0]) begin
               x_in     = '0;
               y_in     = y_ff + YW'(1);
               state_in = S_SC_RD;
            end else begin
               x_in     = x_ff + XW'(1);
               state_in = S_SC_RD;
            end
         end

         // Back path from the end cell: each cell is read, recorded and replaced by its predecessor.
         S_TR_RD: begin
            cell_re    = 1'b1;
            cell_raddr = cur_ff;
            state_in   = S_TR_CHK;
         end

         S_TR_CHK: begin
            path_we = 1'b1;
            len_in  = len_ff + LW'(1);
            cur_in  = cell_rd_ff.pred;
            if (cell_rd_ff.pred == start_ff) begin
               status_in = ST_OK;
               state_in  = S_DONE;
            end else begin
               state_in = S_TR_RD;
            end
         end

         S_DONE: begin
            res_push             = 1'b1;
            res_item.result_kind = KIND_SOLVE;
            res_item.status      = status_ff;
            res_item.path_length = len_ff;
            if (res_ready) begin
               state_in = S_IDLE;
            end
         end

         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         len_ff   <= '0;
      end else begin
         state_ff <= state_in;
         len_ff   <= len_in;
      end
   end

   always_ff @(posedge clock) begin
      start_ff  <= start_in;
      fin_ff    <= fin_in;
      x_ff      <= x_in;
      y_ff      <= y_in;
      d_ff      <= d_in;
      found_ff  <= found_in;
      cur_ff    <= cur_in;
      k_ff      <= k_in;
      nb_ff     <= nb_in;
      status_ff <= status_in;
      idx_ok_ff <= idx_ok_in;
   end

   // Cell memory: per-field write enables, registered read.
   always_ff @(posedge clock) begin
      if (we_blk) begin
         cell_mem[cell_waddr].blocked <= wd_blk;
      end
      if (we_dist) begin
         cell_mem[cell_waddr].distance <= wd_dist;
      end
      if (we_pred) begin
         cell_mem[cell_waddr].pred <= cur_ff;
      end
      if (cell_re) begin
         cell_rd_ff <= cell_mem[cell_raddr];
      end
   end

   // Path memory: written during the trace, read by step requests.
   always_ff @(posedge clock) begin
      if (path_we) begin
         path_mem[len_ff] <= cur_ff;
      end
      if (path_re) begin
         path_rd_ff <= path_mem[req_item.step_index];
      end
   end

endmodule

### design/grid_shortest_path_core.sv
`timescale 1ns / 1ps
// Cell load: one item per cycle while the engine is idle, no result. Path-step read: the
// engine takes no new request until its result has been pushed to the output register.
// Solve: a raster sweep over the grid in use for each distance level, a read of each
// existing neighbor of each settled cell, a distance init of every cell in use, and a
// back trace with one cell memory read per path step.
// Reset is synchronous: it clears the sequencer, output valid and recorded length, and sets
// both size registers to 32. Grid memories are not cleared.

module grid_shortest_path_core import gsp_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // cell_x[4:0], cell_y[9:5], cell_blocked[10], start_x[15:11], start_y[20:16],
   // end_x[25:21], end_y[30:26], step_index[40:31], zero fill [47:41]
   input  logic [47:0] req_tdata,
   // mode[1:0]
   input  logic [1:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // status[1:0], path_length[11:2], step_x[16:12], step_y[21:17], zero fill [23:22]
   output logic [23:0] rsp_tdata,
   // result_kind[0]
   output logic        rsp_tuser,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   cfg_type      cfg;
   req_item_type req_item;
   result_type   res_item, rsp_item;
   logic         res_push, res_ready;

   // Unpack the input item.
   assign req_item.mode         = req_tuser;
   assign req_item.cell_x       = req_tdata[4:0];
   assign req_item.cell_y       = req_tdata[9:5];
   assign req_item.cell_blocked = req_tdata[10];
   assign req_item.start_x      = req_tdata[15:11];
   assign req_item.start_y      = req_tdata[20:16];
   assign req_item.end_x        = req_tdata[25:21];
   assign req_item.end_y        = req_tdata[30:26];
   assign req_item.step_index   = req_tdata[40:31];

   gsp_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   gsp_engine u_engine (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .req_valid (req_tvalid),
      .req_item  (req_item),
      .req_ready (req_tready),
      .res_push  (res_push),
      .res_item  (res_item),
      .res_ready (res_ready)
   );

   gsp_out_stage u_out (
      .clock      (clock),
      .reset      (reset),
      .push       (res_push),
      .push_item  (res_item),
      .push_ready (res_ready),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .rsp_item   (rsp_item)
   );

   // Pack the result item.
   assign rsp_tuser = rsp_item.result_kind;
   assign rsp_tdata = {2'b00, rsp_item.step_y, rsp_item.step_x,
                       rsp_item.path_length, rsp_item.status};

`ifndef SYNTHESIS
   // A solve answer never carries a step cell.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp_tuser == KIND_SOLVE)) |-> (rsp_tdata[21:12] == '0))
      else $error("solve answer carries a step cell");

   // A solve answer never reports a step-index error.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp_tuser == KIND_SOLVE)) |-> (rsp_tdata[1:0] != ST_BAD_STEP))
      else $error("solve answer with step status");

   // A failed solve leaves no recorded path.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp_tuser == KIND_SOLVE) && (rsp_tdata[1:0] != ST_OK))
         |-> (rsp_tdata[11:2] == '0))
      else $error("failed solve with nonzero length");

   // A rejected step read carries no cell.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp_tuser == KIND_STEP) && (rsp_tdata[1:0] == ST_BAD_STEP))
         |-> (rsp_tdata[21:12] == '0))
      else $error("rejected step read carries a cell");
`endif

endmodule

### verif/grid_shortest_path_core_test.sv
`timescale 1ns / 1ps

module grid_shortest_path_core_test;
   import gsp_pkg::*;

   localparam logic [1:0] MODE_UNUSED = 2'd3;
   localparam int unsigned DIST_NONE = 32'hFFFF_FFFF;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [47:0] req_tdata = '0;
   logic [1:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;
   logic        rsp_tuser;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [2:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   grid_shortest_path_core dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata), .csr_pready(csr_pready)
   );

   always #2 clock = ~clock;

   // Shadow copy of the block state used to predict answers.
   bit          cell_blocked_map [CELLS];
   int unsigned route_dist [CELLS];
   bit          route_done [CELLS];
   int          route_from [CELLS];
   int          route_cells [CELLS];
   int          route_len = 0;
   logic [5:0]  cols_reg = 6'd32;
   logic [5:0]  rows_reg = 6'd32;

   req_item_type pending_requests [$];
   result_type   expected_answers [$];
   int           error_count = 0;
   bit           steady_phase = 1'b0;

   function automatic int clamp_size(logic [5:0] v, int top);
      return (v > top) ? top : int'(v);
   endfunction

   // Relax one neighbor of the current cell if it lies on a free cell in the grid.
   function automatic void relax_toward(int cur, int nx, int ny, int w, int h);
      int nb;
      if (nx < 0 || ny < 0 || nx >= w || ny >= h) return;
      nb = ny * MAX_WIDTH + nx;
      if (cell_blocked_map[nb]) return;
      if (route_dist[nb] > route_dist[cur]) begin
         route_dist[nb] = route_dist[cur] + 1;
         route_from[nb] = cur;
      end
   endfunction

   // Unit-step search from start to end; records the back path on success.
   function automatic logic [1:0] solve_route(int sx, int sy, int ex, int ey);
      int w, h, start, fin, cur, nxt, cx, cy, i, guard;
      w = clamp_size(cols_reg, MAX_WIDTH);
      h = clamp_size(rows_reg, MAX_HEIGHT);
      route_len = 0;
      if (sx >= w || sy >= h || ex >= w || ey >= h) return ST_BAD_END;
      start = sy * MAX_WIDTH + sx;
      fin = ey * MAX_WIDTH + ex;
      if (cell_blocked_map[start] || cell_blocked_map[fin]) return ST_BAD_END;
      if (start == fin) return ST_OK;
      for (int y = 0; y < h; y++)
         for (int x = 0; x < w; x++) begin
            route_dist[y * MAX_WIDTH + x] = DIST_NONE;
            route_done[y * MAX_WIDTH + x] = 1'b0;
         end
      route_dist[start] = 0;
      cur = start;
      while (cur != fin) begin
         cx = cur % MAX_WIDTH;
         cy = cur / MAX_WIDTH;
         relax_toward(cur, cx, cy - 1, w, h);
         relax_toward(cur, cx, cy + 1, w, h);
         relax_toward(cur, cx - 1, cy, w, h);
         relax_toward(cur, cx + 1, cy, w, h);
         route_done[cur] = 1'b1;
         nxt = fin;
         for (int y = 0; y < h; y++)
            for (int x = 0; x < w; x++) begin
               i = y * MAX_WIDTH + x;
               if (!cell_blocked_map[i] && route_dist[i] < route_dist[nxt] && !route_done[i])
                  nxt = i;
            end
         cur = nxt;
      end
      if (route_dist[fin] == DIST_NONE) return ST_UNREACHABLE;
      cur = fin;
      guard = 0;
      while (cur != start && guard < CELLS) begin
         route_cells[route_len] = cur;
         route_len++;
         cur = route_from[cur];
         guard++;
      end
      return ST_OK;
   endfunction

   // Update the shadow state for one item, store any answer it has and queue it for the driver.
   function automatic void send(req_item_type it);
      result_type ans;
      ans = '0;
      case (it.mode)
         MODE_LOAD: begin
            cell_blocked_map[it.cell_y * MAX_WIDTH + it.cell_x] = it.cell_blocked;
         end
         MODE_SOLVE: begin
            ans.result_kind = KIND_SOLVE;
            ans.status = solve_route(it.start_x, it.start_y, it.end_x, it.end_y);
            ans.path_length = route_len[LW-1:0];
            expected_answers.push_back(ans);
         end
         MODE_STEP: begin
            ans.result_kind = KIND_STEP;
            ans.path_length = route_len[LW-1:0];
            if (it.step_index < route_len) begin
               ans.status = ST_OK;
               ans.step_x = XW'(route_cells[it.step_index] % MAX_WIDTH);
               ans.step_y = YW'(route_cells[it.step_index] / MAX_WIDTH);
            end else begin
               ans.status = ST_BAD_STEP;
            end
            expected_answers.push_back(ans);
         end
         default: ;
      endcase
      pending_requests.push_back(it);
   endfunction

   // Random item with the fields that matter for its mode set as given.
   function automatic req_item_type make_item(logic [1:0] m, int x0, int y0, int x1, int y1,
                                              int idx, bit blk);
      req_item_type it;
      logic [63:0]  noise;
      noise = {$urandom(), $urandom()};
      it = noise[$bits(req_item_type)-1:0];
      it.mode = m;
      if (m == MODE_LOAD) begin
         it.cell_x = XW'(x0);
         it.cell_y = YW'(y0);
         it.cell_blocked = blk;
      end else if (m == MODE_SOLVE) begin
         it.start_x = XW'(x0);
         it.start_y = YW'(y0);
         it.end_x = XW'(x1);
         it.end_y = YW'(y1);
      end else if (m == MODE_STEP) begin
         it.step_index = LW'(idx);
      end
      return it;
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (steady_phase || r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic int pick_step_index();
      if (route_len > 0 && $urandom_range(0, 5) != 0) return $urandom_range(0, route_len - 1);
      return $urandom_range(route_len, 1023);
   endfunction

   task automatic report_mismatch(string what, int got, int want);
      $display("mismatch in %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
      error_count++;
   endtask

   // Driver: offers queued items, with random gaps after each accepted item.
   req_item_type drive_item;
   int           req_gap = 0;

   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_gap = 0;
      end else if (!req_tvalid || req_tready) begin
         if (req_gap > 0) begin
            req_gap--;
            req_tvalid <= 1'b0;
         end else if (pending_requests.size() > 0) begin
            drive_item = pending_requests.pop_front();
            req_tdata <= {7'b0, drive_item.step_index, drive_item.end_y, drive_item.end_x,
                          drive_item.start_y, drive_item.start_x, drive_item.cell_blocked,
                          drive_item.cell_y, drive_item.cell_x};
            req_tuser <= drive_item.mode;
            req_tvalid <= 1'b1;
            req_gap = pick_gap();
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Monitor: checks each accepted result and stalls the result side at random.
   result_type want_item;
   int         results_seen = 0;
   int         rsp_gap = 0;
   int         hold_cycles = 0;
   bit         long_hold_done = 1'b0;

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            results_seen++;
            rsp_gap = pick_gap();
            if (expected_answers.size() == 0) begin
               report_mismatch("unexpected result kind", rsp_tuser, -1);
            end else begin
               want_item = expected_answers.pop_front();
               if (rsp_tuser !== want_item.result_kind)
                  report_mismatch("result_kind", rsp_tuser, want_item.result_kind);
               if (rsp_tdata[1:0] !== want_item.status)
                  report_mismatch("status", rsp_tdata[1:0], want_item.status);
               if (rsp_tdata[11:2] !== want_item.path_length)
                  report_mismatch("path_length", rsp_tdata[11:2], want_item.path_length);
               if (rsp_tdata[16:12] !== want_item.step_x)
                  report_mismatch("step_x", rsp_tdata[16:12], want_item.step_x);
               if (rsp_tdata[21:17] !== want_item.step_y)
                  report_mismatch("step_y", rsp_tdata[21:17], want_item.step_y);
            end
         end
         // One long hold-off lets the block back up and stall its input.
         if (hold_cycles > 0) begin
            hold_cycles--;
            rsp_tready <= 1'b0;
         end else if (!long_hold_done && results_seen >= 60) begin
            long_hold_done = 1'b1;
            hold_cycles = 500;
            rsp_tready <= 1'b0;
         end else if (rsp_gap > 0) begin
            rsp_gap--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   task automatic wait_idle();
      while (pending_requests.size() > 0 || expected_answers.size() > 0 || req_tvalid)
         @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic csr_write(logic idx, logic [5:0] value);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= {26'b0, value};
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
   endtask

   // One setting of the grid size: reload small grids, then a random mix of items.
   task automatic run_phase(logic [5:0] cols, logic [5:0] rows, int ops);
      int w, h, r, steps;
      bit inside_grid;
      wait_idle();
      csr_write(REG_WIDTH, cols);
      csr_write(REG_HEIGHT, rows);
      cols_reg = cols;
      rows_reg = rows;
      steady_phase = ($urandom_range(0, 3) == 0);
      w = clamp_size(cols, MAX_WIDTH);
      h = clamp_size(rows, MAX_HEIGHT);
      if (w * h <= 100)
         for (int y = 0; y < h; y++)
            for (int x = 0; x < w; x++)
               send(make_item(MODE_LOAD, x, y, 0, 0, 0, $urandom_range(0, 99) < 25));
      for (int n = 0; n < ops; n++) begin
         r = $urandom_range(0, 99);
         inside_grid = (w > 0 && h > 0);
         if (r < 30) begin
            // A solve is mostly followed by reads along its recorded path.
            if (inside_grid && $urandom_range(0, 4) != 0) begin
               send(make_item(MODE_SOLVE, $urandom_range(0, w - 1), $urandom_range(0, h - 1),
                              $urandom_range(0, w - 1), $urandom_range(0, h - 1), 0, 0));
            end else if (inside_grid && $urandom_range(0, 1) == 0) begin
               w = w;
               r = $urandom_range(0, w - 1);
               steps = $urandom_range(0, h - 1);
               send(make_item(MODE_SOLVE, r, steps, r, steps, 0, 0));
            end else begin
               send(make_item(MODE_SOLVE, $urandom_range(0, 31), $urandom_range(0, 31),
                              $urandom_range(0, 31), $urandom_range(0, 31), 0, 0));
            end
            steps = $urandom_range(0, 5);
            for (int k = 0; k < steps; k++)
               send(make_item(MODE_STEP, 0, 0, 0, 0, pick_step_index(), 0));
         end else if (r < 55) begin
            send(make_item(MODE_STEP, 0, 0, 0, 0, pick_step_index(), 0));
         end else if (r < 92) begin
            if (inside_grid && $urandom_range(0, 4) != 0)
               send(make_item(MODE_LOAD, $urandom_range(0, w - 1), $urandom_range(0, h - 1),
                              0, 0, 0, $urandom_range(0, 99) < 30));
            else
               send(make_item(MODE_LOAD, $urandom_range(0, 31), $urandom_range(0, 31),
                              0, 0, 0, $urandom_range(0, 1)));
         end else begin
            send(make_item(MODE_UNUSED, 0, 0, 0, 0, 0, 0));
         end
      end
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Define every cell of the store as free before any search reads it.
      for (int y = 0; y < MAX_HEIGHT; y++)
         for (int x = 0; x < MAX_WIDTH; x++)
            send(make_item(MODE_LOAD, x, y, 0, 0, 0, 0));

      // Directed items on the full open grid.
      send(make_item(MODE_STEP, 0, 0, 0, 0, 0, 0));
      send(make_item(MODE_UNUSED, 0, 0, 0, 0, 0, 0));
      send(make_item(MODE_SOLVE, 0, 0, 31, 31, 0, 0));
      send(make_item(MODE_STEP, 0, 0, 0, 0, 0, 0));
      send(make_item(MODE_STEP, 0, 0, 0, 0, 61, 0));
      send(make_item(MODE_STEP, 0, 0, 0, 0, 62, 0));
      send(make_item(MODE_STEP, 0, 0, 0, 0, 1023, 0));
      send(make_item(MODE_SOLVE, 5, 5, 5, 5, 0, 0));
      send(make_item(MODE_LOAD, 31, 31, 0, 0, 0, 1));
      send(make_item(MODE_SOLVE, 0, 0, 31, 31, 0, 0));
      send(make_item(MODE_SOLVE, 31, 31, 0, 0, 0, 0));
      send(make_item(MODE_STEP, 0, 0, 0, 0, 0, 0));
      // Walling in the corner start makes the end unreachable.
      send(make_item(MODE_LOAD, 1, 0, 0, 0, 0, 1));
      send(make_item(MODE_LOAD, 0, 1, 0, 0, 0, 1));
      send(make_item(MODE_SOLVE, 0, 0, 5, 5, 0, 0));
      send(make_item(MODE_STEP, 0, 0, 0, 0, 3, 0));
      send(make_item(MODE_SOLVE, 31, 0, 0, 30, 0, 0));
      send(make_item(MODE_STEP, 0, 0, 0, 0, 0, 0));
      send(make_item(MODE_STEP, 0, 0, 0, 0, 59, 0));
      send(make_item(MODE_LOAD, 31, 31, 0, 0, 0, 0));

      // Size extremes first, then small random grids.
      run_phase(6'd2, 6'd2, 20);
      run_phase(6'd0, 6'd5, 10);
      run_phase(6'd5, 6'd0, 10);
      run_phase(6'd1, 6'd1, 15);
      run_phase(6'd1, 6'd32, 20);
      run_phase(6'd32, 6'd1, 20);
      run_phase(6'd3, 6'd40, 20);
      run_phase(6'd63, 6'd63, 8);
      for (int p = 0; p < 8; p++)
         run_phase($urandom_range(2, 8), $urandom_range(2, 8), 25);

      wait_idle();
      if (error_count == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

   initial begin
      #40_000_000;
      $display("TB_ERROR");
      $finish;
   end

endmodule
